>>> hw/rtl/variable_partition_allocator_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define VPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpa assertion failed");
`define VPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpa assertion failed");
`else
`define VPA_ASSERT_SAME(lbl, ante, cons)
`define VPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/vpa_pkg.sv
// Types, codes and defaults of the variable partition allocator.
package vpa_pkg;

  localparam int DEF_ADDR_WIDTH = 16;
  localparam int DEF_MAX_HOLES  = 16;
  localparam int DEF_MAX_ALLOCS = 16;
  localparam int CFG_AW         = 3;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_SPARE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] FIT_SPARE = 2'd0;
  localparam logic [1:0] FIT_FIRST = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] base_addr;
    logic [15:0] region_size;
  } vpa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_base;
    logic [15:0] result_size;
    logic [4:0]  hole_count;
  } vpa_out_t;

endpackage

>>> hw/rtl/vpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/variable_partition_allocator.sv
// Top level: hole and allocation tables with a sequencer over one read port each.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-----------------------------------
//  input    | start, busy, in_data           | beat taken when start && !busy
//  result   | out_valid, out_data            | one-cycle strobe, no back-pressure
//  config   | psel penable pwrite paddr ...  | APB write on access cycle, pready=1
//
// Every table entry is read through one registered RAM port, address then data.
// add: an insert pass over the holes in use; request: a scan, then a copy pass;
// release: an allocation scan plus an add pass. Hole table is double-buffered,
// each update rewrites it into the idle bank. Reset is synchronous, clears the
// hole count, allocation valid bits and fit_mode (first fit); tables need no sweep.
// busy stays high from the accepted beat until the result strobe.
`include "variable_partition_allocator_macros.svh"
module variable_partition_allocator #(
  parameter int ADDR_WIDTH = vpa_pkg::DEF_ADDR_WIDTH,
  parameter int MAX_HOLES  = vpa_pkg::DEF_MAX_HOLES,
  parameter int MAX_ALLOCS = vpa_pkg::DEF_MAX_ALLOCS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  vpa_pkg::vpa_in_t          in_data,
  output logic                      out_valid,
  output vpa_pkg::vpa_out_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vpa_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int HAW = $clog2(MAX_HOLES);
  localparam int HCW = $clog2(MAX_HOLES + 1);
  localparam int AAW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int LIM = (MAX_HOLES > MAX_ALLOCS) ? MAX_HOLES : MAX_ALLOCS;
  localparam int IW  = $clog2(LIM + 1);
  localparam int LW  = ADDR_WIDTH + 1;
  localparam int HW  = ADDR_WIDTH + LW;
  localparam int ADW = ADDR_WIDTH + 16;
  localparam int CW  = (LW > 17) ? LW : 17;
  localparam logic [CW-1:0] SPACE = CW'(1) << ADDR_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_REQ_SCAN, S_REQ_COPY, S_REL_SCAN, S_INS, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic ph_r, ph_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [HCW-1:0] m_r, m_nxt, n_r, n_nxt;
  logic cur_r, cur_nxt;
  logic [1:0] fit_r, fit_nxt;
  logic [1:0] act_r, act_nxt;
  logic [ADDR_WIDTH-1:0] b_r, b_nxt;
  logic [15:0] s_r, s_nxt;
  logic [LW-1:0] ib_r, ib_nxt, ie_r, ie_nxt;
  logic placed_r, placed_nxt, touched_r, touched_nxt;
  logic found_r, found_nxt;
  logic [HAW-1:0] pick_r, pick_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [ADDR_WIDTH-1:0] pbase_r, pbase_nxt;
  logic afound_r, afound_nxt;
  logic [AAW-1:0] aidx_r, aidx_nxt;
  logic [1:0] st_r, st_nxt;
  logic [ADDR_WIDTH-1:0] rb_r, rb_nxt;
  logic [15:0] rs_r, rs_nxt;
  logic [MAX_ALLOCS-1:0] valid_r, valid_nxt;
  logic out_valid_r, out_valid_nxt;
  vpa_pkg::vpa_out_t out_r, out_nxt;

  logic h_we, a_we;
  logic [HAW-1:0] h_waddr;
  logic [HW-1:0] h_wdata, h_rd0, h_rd1, h_rd;
  logic [ADW-1:0] a_wdata, a_rd;
  logic [ADDR_WIDTH-1:0] hb, ab, in_b;
  logic [LW-1:0] hl, he, nl;
  logic [15:0] al;
  logic [CW-1:0] room, sc;
  logic fits;
  logic cfg_wr;

  vpa_ram #(.WIDTH(HW), .DEPTH(MAX_HOLES)) u_hole0 (
    .clk(clk), .we(h_we && cur_r), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(idx_r[HAW-1:0]), .rdata(h_rd0)
  );
  vpa_ram #(.WIDTH(HW), .DEPTH(MAX_HOLES)) u_hole1 (
    .clk(clk), .we(h_we && !cur_r), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(idx_r[HAW-1:0]), .rdata(h_rd1)
  );
  vpa_ram #(.WIDTH(ADW), .DEPTH(MAX_ALLOCS)) u_alloc (
    .clk(clk), .we(a_we), .waddr(aidx_r), .wdata(a_wdata),
    .raddr(idx_r[AAW-1:0]), .rdata(a_rd)
  );

  assign h_rd = cur_r ? h_rd1 : h_rd0;
  assign hb   = h_rd[ADDR_WIDTH-1:0];
  assign hl   = h_rd[ADDR_WIDTH +: LW];
  assign he   = LW'(hb) + hl;
  assign nl   = hl - LW'(s_r);
  assign ab   = a_rd[ADDR_WIDTH-1:0];
  assign al   = a_rd[ADDR_WIDTH +: 16];
  assign in_b = ADDR_WIDTH'(in_data.base_addr);
  assign room = SPACE - CW'(in_b);
  assign sc   = (CW'(in_data.region_size) > room) ? room : CW'(in_data.region_size);
  assign fits = found_r && (CW'(plen_r) >= CW'(s_r));
  assign cfg_wr = psel && penable && pwrite && pready;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : {30'd0, fit_r};

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; idx_nxt = idx_r; m_nxt = m_r; n_nxt = n_r;
    cur_nxt = cur_r; fit_nxt = fit_r; act_nxt = act_r; b_nxt = b_r; s_nxt = s_r;
    ib_nxt = ib_r; ie_nxt = ie_r; placed_nxt = placed_r; touched_nxt = touched_r;
    found_nxt = found_r; pick_nxt = pick_r; plen_nxt = plen_r; pbase_nxt = pbase_r;
    afound_nxt = afound_r; aidx_nxt = aidx_r; st_nxt = st_r; rb_nxt = rb_r;
    rs_nxt = rs_r; valid_nxt = valid_r; out_valid_nxt = 1'b0; out_nxt = out_r;
    h_we = 1'b0; h_waddr = m_r[HAW-1:0]; h_wdata = {hl, hb};
    a_we = 1'b0; a_wdata = {s_r, pbase_r};

    if (cfg_wr && !paddr[2]) begin
      fit_nxt = pwdata[1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = in_data.action; b_nxt = in_b; s_nxt = in_data.region_size;
          st_nxt = vpa_pkg::ST_OK; rb_nxt = '0; rs_nxt = '0;
          idx_nxt = '0; ph_nxt = 1'b0; m_nxt = '0;
          placed_nxt = 1'b0; touched_nxt = 1'b0;
          found_nxt = 1'b0; afound_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_data.action)
            vpa_pkg::ACT_ADD: begin
              if (sc != '0) begin
                ib_nxt = LW'(in_b); ie_nxt = LW'(in_b) + LW'(sc);
                rb_nxt = in_b; rs_nxt = 16'(sc);
                state_nxt = S_INS;
              end
            end
            vpa_pkg::ACT_REQUEST: begin
              if (in_data.region_size == '0) st_nxt = vpa_pkg::ST_NOFIT;
              else state_nxt = S_REQ_SCAN;
            end
            vpa_pkg::ACT_RELEASE: state_nxt = S_REL_SCAN;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_REQ_SCAN: begin
        if (!ph_r) begin
          if (idx_r >= IW'(n_r) && idx_r >= IW'(MAX_ALLOCS)) begin
            idx_nxt = '0; m_nxt = '0;
            if (!fits) begin
              st_nxt = vpa_pkg::ST_NOFIT; state_nxt = S_DONE;
            end else if (!afound_r) begin
              st_nxt = vpa_pkg::ST_FULL; state_nxt = S_DONE;
            end else begin
              state_nxt = S_REQ_COPY;
            end
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          if (idx_r < IW'(n_r)) begin
            case (fit_r)
              vpa_pkg::FIT_BEST: begin
                if (CW'(hl) >= CW'(s_r) && (!found_r || hl < plen_r)) begin
                  found_nxt = 1'b1; pick_nxt = idx_r[HAW-1:0];
                  plen_nxt = hl; pbase_nxt = hb;
                end
              end
              vpa_pkg::FIT_WORST: begin
                if (!found_r || hl > plen_r) begin
                  found_nxt = 1'b1; pick_nxt = idx_r[HAW-1:0];
                  plen_nxt = hl; pbase_nxt = hb;
                end
              end
              default: begin
                if (!found_r && CW'(hl) >= CW'(s_r)) begin
                  found_nxt = 1'b1; pick_nxt = idx_r[HAW-1:0];
                  plen_nxt = hl; pbase_nxt = hb;
                end
              end
            endcase
          end
          if (idx_r < IW'(MAX_ALLOCS) && !afound_r && !valid_r[idx_r[AAW-1:0]]) begin
            afound_nxt = 1'b1; aidx_nxt = idx_r[AAW-1:0];
          end
          idx_nxt = idx_r + 1'b1; ph_nxt = 1'b0;
        end
      end

      S_REQ_COPY: begin
        if (!ph_r) begin
          if (idx_r == IW'(n_r)) begin
            cur_nxt = !cur_r; n_nxt = m_r;
            a_we = 1'b1; valid_nxt[aidx_r] = 1'b1;
            rb_nxt = pbase_r; rs_nxt = s_r;
            state_nxt = S_DONE;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          // carve the request from the front of the chosen hole, drop it if empty
          if (idx_r[HAW-1:0] == pick_r) begin
            h_wdata = {nl, ADDR_WIDTH'(LW'(hb) + LW'(s_r))};
            h_we = (nl != '0);
          end else begin
            h_we = 1'b1;
          end
          if (h_we) m_nxt = m_r + 1'b1;
          idx_nxt = idx_r + 1'b1; ph_nxt = 1'b0;
        end
      end

      S_REL_SCAN: begin
        if (!ph_r) begin
          if (idx_r == IW'(MAX_ALLOCS)) begin
            st_nxt = vpa_pkg::ST_NOTFOUND; state_nxt = S_DONE;
          end else begin
            ph_nxt = 1'b1;
          end
        end else if (valid_r[idx_r[AAW-1:0]] && ab == b_r) begin
          aidx_nxt = idx_r[AAW-1:0];
          ib_nxt = LW'(ab); ie_nxt = LW'(ab) + LW'(al);
          rb_nxt = ab; rs_nxt = al;
          idx_nxt = '0; ph_nxt = 1'b0; m_nxt = '0;
          state_nxt = S_INS;
        end else begin
          idx_nxt = idx_r + 1'b1; ph_nxt = 1'b0;
        end
      end

      S_INS: begin
        if (!ph_r) begin
          if (idx_r == IW'(n_r)) begin
            state_nxt = S_DONE;
            if (!touched_r && n_r == HCW'(MAX_HOLES)) begin
              st_nxt = vpa_pkg::ST_FULL; rb_nxt = '0; rs_nxt = '0;
            end else begin
              if (!placed_r) begin
                h_we = 1'b1; h_wdata = {ie_r - ib_r, ADDR_WIDTH'(ib_r)};
                n_nxt = m_r + 1'b1;
              end else begin
                n_nxt = m_r;
              end
              cur_nxt = !cur_r;
              if (act_r == vpa_pkg::ACT_RELEASE) valid_nxt[aidx_r] = 1'b0;
            end
          end else begin
            ph_nxt = 1'b1;
          end
        end else if (LW'(hb) <= ie_r && he >= ib_r) begin
          // absorb an overlapping or touching hole
          touched_nxt = 1'b1;
          if (LW'(hb) < ib_r) ib_nxt = LW'(hb);
          if (he > ie_r) ie_nxt = he;
          idx_nxt = idx_r + 1'b1; ph_nxt = 1'b0;
        end else if (!placed_r && LW'(hb) > ie_r) begin
          // write the new hole first, hold this entry for the next cycle
          h_we = 1'b1; h_wdata = {ie_r - ib_r, ADDR_WIDTH'(ib_r)};
          m_nxt = m_r + 1'b1; placed_nxt = 1'b1;
        end else begin
          h_we = 1'b1; m_nxt = m_r + 1'b1;
          idx_nxt = idx_r + 1'b1; ph_nxt = 1'b0;
        end
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt.status = st_r;
        out_nxt.result_base = 16'(rb_r);
        out_nxt.result_size = rs_r;
        out_nxt.hole_count = 5'(n_r);
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ph_r <= 1'b0; n_r <= '0; cur_r <= 1'b0;
      fit_r <= vpa_pkg::FIT_FIRST; valid_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ph_r <= ph_nxt; n_r <= n_nxt; cur_r <= cur_nxt;
      fit_r <= fit_nxt; valid_r <= valid_nxt; out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt; m_r <= m_nxt; act_r <= act_nxt; b_r <= b_nxt; s_r <= s_nxt;
    ib_r <= ib_nxt; ie_r <= ie_nxt; placed_r <= placed_nxt; touched_r <= touched_nxt;
    found_r <= found_nxt; pick_r <= pick_nxt; plen_r <= plen_nxt; pbase_r <= pbase_nxt;
    afound_r <= afound_nxt; aidx_r <= aidx_nxt; st_r <= st_nxt; rb_r <= rb_nxt;
    rs_r <= rs_nxt; out_r <= out_nxt;
  end

  `VPA_ASSERT_SAME(a_strobe_idle, out_valid, !busy)
  `VPA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `VPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `VPA_ASSERT_SAME(a_hole_bound, 1'b1, n_r <= HCW'(MAX_HOLES))

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the variable partition allocator.
module tb;

  localparam int HOLES   = 16;
  localparam int ALLOCS  = 16;
  localparam int SPACE   = 65536;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  vpa_pkg::vpa_in_t in_data = '0;
  logic out_valid;
  vpa_pkg::vpa_out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [vpa_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #1 clk = ~clk;

  variable_partition_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  int unsigned free_base [HOLES];
  int unsigned free_len [HOLES];
  int unsigned free_cnt;
  int unsigned live_base [ALLOCS];
  int unsigned live_len [ALLOCS];
  bit live_ok [ALLOCS];
  logic [1:0] policy;

  vpa_pkg::vpa_out_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic bit merge_region(int unsigned b, int unsigned len);
    int unsigned e, hb, he, m, hits;
    int unsigned nb [HOLES];
    int unsigned nl [HOLES];
    bit placed;
    e = b + len;
    m = 0;
    hits = 0;
    placed = 0;
    for (int i = 0; i < free_cnt; i++) begin
      hb = free_base[i];
      he = hb + free_len[i];
      if (hb <= e && he >= b) hits++;
    end
    if (hits == 0 && free_cnt >= HOLES) return 0;
    for (int i = 0; i < free_cnt; i++) begin
      hb = free_base[i];
      he = hb + free_len[i];
      if (hb <= e && he >= b) begin
        if (hb < b) b = hb;
        if (he > e) e = he;
        continue;
      end
      if (!placed && hb > e && m < HOLES) begin
        nb[m] = b; nl[m] = e - b; m++; placed = 1;
      end
      if (m < HOLES) begin
        nb[m] = hb; nl[m] = he - hb; m++;
      end
    end
    if (!placed && m < HOLES) begin
      nb[m] = b; nl[m] = e - b; m++;
    end
    for (int i = 0; i < m; i++) begin
      free_base[i] = nb[i];
      free_len[i] = nl[i];
    end
    free_cnt = m;
    return 1;
  endfunction

  function automatic int pick_hole(int unsigned s);
    int pick;
    pick = -1;
    for (int i = 0; i < free_cnt; i++) begin
      if (policy == vpa_pkg::FIT_BEST) begin
        if (free_len[i] >= s && (pick < 0 || free_len[i] < free_len[pick])) pick = i;
      end else if (policy == vpa_pkg::FIT_WORST) begin
        if (pick < 0 || free_len[i] > free_len[pick]) pick = i;
      end else if (free_len[i] >= s) begin
        return i;
      end
    end
    if (pick >= 0 && free_len[pick] < s) pick = -1;
    return pick;
  endfunction

  function automatic vpa_pkg::vpa_out_t allocate_step(vpa_pkg::vpa_in_t item);
    vpa_pkg::vpa_out_t r;
    int unsigned b, s, k, a;
    int h;
    r = '0;
    r.status = vpa_pkg::ST_OK;
    b = 32'(item.base_addr);
    s = 32'(item.region_size);
    if (item.action == vpa_pkg::ACT_ADD) begin
      if (s > SPACE - b) s = SPACE - b;
      if (s > 0) begin
        if (merge_region(b, s)) begin
          r.result_base = 16'(b); r.result_size = 16'(s);
        end else r.status = vpa_pkg::ST_FULL;
      end
    end else if (item.action == vpa_pkg::ACT_REQUEST) begin
      h = (s == 0) ? -1 : pick_hole(s);
      if (h < 0) r.status = vpa_pkg::ST_NOFIT;
      else begin
        for (a = 0; a < ALLOCS && live_ok[a]; a++) ;
        if (a >= ALLOCS) r.status = vpa_pkg::ST_FULL;
        else begin
          k = unsigned'(h);
          r.result_base = 16'(free_base[k]);
          r.result_size = 16'(s);
          live_ok[a] = 1; live_base[a] = free_base[k]; live_len[a] = s;
          free_base[k] += s;
          free_len[k] -= s;
          if (free_len[k] == 0) begin
            while (k + 1 < free_cnt) begin
              free_base[k] = free_base[k + 1];
              free_len[k] = free_len[k + 1];
              k++;
            end
            free_cnt--;
          end
        end
      end
    end else if (item.action == vpa_pkg::ACT_RELEASE) begin
      for (a = 0; a < ALLOCS; a++)
        if (live_ok[a] && live_base[a] == b) break;
      if (a >= ALLOCS) r.status = vpa_pkg::ST_NOTFOUND;
      else if (!merge_region(live_base[a], live_len[a])) r.status = vpa_pkg::ST_FULL;
      else begin
        r.result_base = 16'(live_base[a]); r.result_size = 16'(live_len[a]);
        live_ok[a] = 0;
      end
    end
    r.hole_count = 5'(free_cnt);
    return r;
  endfunction

  // Check each result beat
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      vpa_pkg::vpa_out_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.result_base !== want.result_base) begin
          $error("result_base: expected %0d actual %0d", want.result_base,
                 out_data.result_base);
          errors++;
        end
        if (out_data.result_size !== want.result_size) begin
          $error("result_size: expected %0d actual %0d", want.result_size,
                 out_data.result_size);
          errors++;
        end
        if (out_data.hole_count !== want.hole_count) begin
          $error("hole_count: expected %0d actual %0d", want.hole_count,
                 out_data.hole_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("variable_partition_allocator: mismatch");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_item(logic [1:0] act, int unsigned b, int unsigned s);
    vpa_pkg::vpa_in_t item;
    vpa_pkg::vpa_out_t want;
    item.action = act;
    item.base_addr = b[15:0];
    item.region_size = s[15:0];
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = allocate_step(item);
    pending_results = {pending_results, want};
    start <= 1'b0;
    // the block is busy for this cycle anyway; drop start before the next beat
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] mode);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {30'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // read the register back
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1) begin
      $error("pready: expected %0d actual %0d", 1'b1, pready);
      errors++;
    end
    if (prdata !== {30'd0, mode}) begin
      $error("fit_mode: expected %0d actual %0d", mode, prdata);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    policy = mode;
    @(posedge clk);
  endtask

  task automatic send_random(int unsigned n);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        send_item(vpa_pkg::ACT_ADD, $urandom_range(0, 15) * 4096 + $urandom_range(0, 4095),
                  $urandom_range(1, 3000));
      else if (pick < 62)
        send_item(vpa_pkg::ACT_REQUEST, $urandom, ($urandom_range(0, 9) == 0) ? $urandom
                  : $urandom_range(0, 2500));
      else if (pick < 92) begin
        int unsigned a;
        a = $urandom_range(0, ALLOCS - 1);
        send_item(vpa_pkg::ACT_RELEASE, live_ok[a] ? live_base[a] : $urandom, $urandom);
      end else if (pick < 97)
        send_item(vpa_pkg::ACT_ADD, $urandom, $urandom);
      else
        send_item(vpa_pkg::ACT_SPARE, $urandom, $urandom);
    end
  endtask

  task automatic test_directed();
    send_item(vpa_pkg::ACT_REQUEST, 0, 10);
    send_item(vpa_pkg::ACT_RELEASE, 0, 0);
    send_item(vpa_pkg::ACT_ADD, 100, 0);
    send_item(vpa_pkg::ACT_ADD, 16'hFFF0, 16'hFFFF);
    send_item(vpa_pkg::ACT_ADD, 0, 16'hFFFF);
    send_item(vpa_pkg::ACT_REQUEST, 0, 0);
    send_item(vpa_pkg::ACT_REQUEST, 0, 16'hFFFF);
    send_item(vpa_pkg::ACT_REQUEST, 0, 1);
    send_item(vpa_pkg::ACT_SPARE, 16'hFFFF, 16'hFFFF);
    send_item(vpa_pkg::ACT_RELEASE, 0, 0);
    send_item(vpa_pkg::ACT_RELEASE, 0, 0);
    send_item(vpa_pkg::ACT_RELEASE, 12345, 0);
    for (int i = 0; i < ALLOCS + 1; i++) send_item(vpa_pkg::ACT_REQUEST, 0, 2);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < HOLES + 2; i++) send_item(vpa_pkg::ACT_ADD, 40000 + i * 10, 3);
    for (int i = 0; i < ALLOCS; i++) send_item(vpa_pkg::ACT_RELEASE, 2 * i + 1, 0);
    send_item(vpa_pkg::ACT_ADD, 40001, 100);
  endtask

  task automatic test_policies();
    logic [1:0] modes [4] = '{vpa_pkg::FIT_BEST, vpa_pkg::FIT_WORST, vpa_pkg::FIT_SPARE,
                              vpa_pkg::FIT_FIRST};
    foreach (modes[m]) begin
      write_policy(modes[m]);
      send_random(240);
    end
    send_random(50);
  endtask

  initial begin
    free_cnt = 0;
    policy = vpa_pkg::FIT_FIRST;
    for (int i = 0; i < ALLOCS; i++) live_ok[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_table_full();
    test_policies();
    drain();
    if (errors == 0) $display("variable_partition_allocator: match");
    else $display("variable_partition_allocator: mismatch");
    $finish;
  end
endmodule
